@@ rtl/kmc_pkg.sv @@
// Package for the keyboard/mouse controller: opcodes, command codes and
// reply header bytes. No dependencies.
`default_nettype none
package kmc_pkg;

  localparam logic [2:0] OP_HOST  = 3'd0;
  localparam logic [2:0] OP_MOVE  = 3'd1;
  localparam logic [2:0] OP_BTN   = 3'd2;
  localparam logic [2:0] OP_KEY   = 3'd3;
  localparam logic [2:0] OP_JOY   = 3'd4;
  localparam logic [2:0] OP_TICK  = 3'd5;

  localparam logic [1:0] MODE_REL = 2'd0;
  localparam logic [1:0] MODE_ABS = 2'd1;
  localparam logic [1:0] MODE_OFF = 2'd2;

  localparam logic [7:0] CMD_RESET    = 8'h80;
  localparam logic [7:0] CMD_BTNACT   = 8'h07;
  localparam logic [7:0] CMD_REL      = 8'h08;
  localparam logic [7:0] CMD_ABS      = 8'h09;
  localparam logic [7:0] CMD_KEYCODE  = 8'h0a;
  localparam logic [7:0] CMD_THRESH   = 8'h0b;
  localparam logic [7:0] CMD_SCALE    = 8'h0c;
  localparam logic [7:0] CMD_INTERROG = 8'h0d;
  localparam logic [7:0] CMD_LOADPOS  = 8'h0e;
  localparam logic [7:0] CMD_YUP      = 8'h0f;
  localparam logic [7:0] CMD_YDOWN    = 8'h10;
  localparam logic [7:0] CMD_DISABLE  = 8'h12;
  localparam logic [7:0] CMD_JOYINT   = 8'h16;
  localparam logic [7:0] CMD_JOYMON   = 8'h17;
  localparam logic [7:0] CMD_JOYKEYS  = 8'h19;

  localparam logic [7:0] HDR_RESET = 8'hf0;
  localparam logic [7:0] HDR_POS   = 8'hf7;
  localparam logic [7:0] HDR_REL   = 8'hf8;
  localparam logic [7:0] HDR_JOYI  = 8'hfd;
  localparam logic [7:0] HDR_JOY1  = 8'hfe;
  localparam logic [7:0] HDR_JOY0  = 8'hff;

  localparam int unsigned MAX_CHUNKS = 17;

  function automatic logic [2:0] cmd_len(input logic [7:0] op);
    case (op)
      CMD_RESET, CMD_BTNACT, CMD_JOYMON:  cmd_len = 3'd2;
      CMD_KEYCODE, CMD_THRESH, CMD_SCALE: cmd_len = 3'd3;
      CMD_ABS:                            cmd_len = 3'd5;
      CMD_LOADPOS:                        cmd_len = 3'd6;
      CMD_JOYKEYS:                        cmd_len = 3'd7;
      default:                            cmd_len = 3'd1;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/keyboard_mouse_controller.sv @@
// Keyboard/mouse/joystick controller: one input beat in, zero or more
// reply bytes out. Uses kmc_pkg and kmc_div.
//
// Channels: in_valid_i/in_ready_o carry one event (host byte, mouse
// move, button, key, joystick, tick). out_valid_o/out_ready_i carry reply
// bytes, out_last_o marks the final byte an event causes.
// One event is handled at a time; in_ready_o is low until all its bytes
// are taken. An absolute-mode tick runs the shared bit-serial divider
// twice, once per axis. A relative tick sends up to 17 three-byte
// packets, one byte per cycle while the receiver is ready.
// A stalled receiver holds the sequencer with the byte on the port.
// Reset clears all mouse, joystick and command-assembly state: relative
// mode, thresholds and scales 1, y down, position and ranges 0.
`default_nettype none
module keyboard_mouse_controller
  import kmc_pkg::*;
#(
  parameter int unsigned CMD_DEPTH  = 7,
  parameter int unsigned ACCUM_BITS = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [2:0]         opcode_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic signed [11:0] move_x_i,
  input  wire logic signed [11:0] move_y_i,
  input  wire logic               button_index_i,
  input  wire logic               pressed_i,
  input  wire logic               joystick_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    out_last_o
);
  localparam int unsigned A  = ACCUM_BITS;
  localparam int unsigned CW = $clog2(CMD_DEPTH + 1);
  localparam int unsigned IW = $clog2(CMD_DEPTH);
  localparam logic signed [A-1:0] AMAX = {1'b0, {(A - 1){1'b1}}};
  localparam logic signed [A-1:0] AMIN = {1'b1, {(A - 1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_EMIT, S_RCHK, S_RCHUNK, S_DIVX, S_WAITX,
    S_DIVY, S_WAITY, S_JOY, S_DONE
  } state_e;

  state_e state_q;
  logic [7:0]  cmd_q [CMD_DEPTH];
  logic [CW-1:0] cnt_q;
  logic [1:0]  mode_q;
  logic signed [A-1:0] ax_q, ay_q;
  logic [1:0]  bstate_q, posted_q;
  logic [3:0]  bev_q;
  logic [15:0] pos_q [2];
  logic [15:0] rng_q [2];
  logic [7:0]  thr_q [2];
  logic [7:0]  scl_q [2];
  logic        ydown_q;
  logic [7:0]  joy_q [2];
  logic [1:0]  jpend_q;

  // reply buffer: up to 6 bytes for command replies
  logic [7:0]  rb_q [6];
  logic [2:0]  rn_q, ri_q;
  logic signed [A:0] rx_q, ry_q;
  logic [4:0]  nch_q;
  logic [1:0]  cb_q;            // byte within relative packet
  logic [1:0]  jb_q;            // joystick report phase

  logic        out_valid_q, out_last_q;
  logic [7:0]  out_byte_q;

  // divider
  logic        dv_start, dv_done;
  logic [A-1:0] dv_num, dv_quo, dv_rem;
  logic [7:0]  dv_den;
  logic        dv_neg_q;

  kmc_div #(.N(A)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo), .rem_o(dv_rem)
  );

  logic        in_fire, out_fire;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  logic signed [A-1:0] cur_acc;
  logic [7:0]  cur_scl;
  assign cur_acc = (state_q == S_DIVX) ? ax_q : ay_q;
  assign cur_scl = (state_q == S_DIVX) ? scl_q[0] : scl_q[1];
  assign dv_start = (state_q == S_DIVX) || (state_q == S_DIVY);
  assign dv_num   = cur_acc[A-1] ? A'(-cur_acc) : cur_acc;
  assign dv_den   = (cur_scl == 8'd0) ? 8'd1 : cur_scl;

  function automatic logic signed [A:0] sat_add(input logic signed [A-1:0] a,
                                                input logic signed [11:0] d);
    logic signed [A+12:0] s;
    s = (A + 13)'(a) + (A + 13)'(d);
    if (s > (A + 13)'(AMAX)) sat_add = (A + 1)'(AMAX);
    else if (s < (A + 13)'(AMIN)) sat_add = (A + 1)'(AMIN);
    else sat_add = (A + 1)'(s);
  endfunction

  function automatic logic signed [A:0] chunk(input logic signed [A:0] v);
    if (v >= -(A + 1)'(128) && v < (A + 1)'(127)) chunk = v;
    else if (v > 0) chunk = (A + 1)'(127);
    else chunk = -(A + 1)'(128);
  endfunction

  function automatic logic [A:0] absv(input logic signed [A-1:0] v);
    absv = v[A-1] ? -(A + 1)'(v) : (A + 1)'(v);
  endfunction

  logic signed [A:0] cx, cy, sx, sy;
  logic        rc_end;
  assign cx = chunk(rx_q);
  assign cy = chunk(ry_q);
  assign sx = rx_q - cx;
  assign sy = ry_q - cy;
  assign rc_end = (sx == '0 && sy == '0) || (nch_q + 5'd1 == 5'(MAX_CHUNKS));
  logic signed [A:0] neg_y;
  assign neg_y = -(A + 1)'(ay_q);

  // absolute position update
  logic signed [A:0] q_s;
  logic signed [17:0] pnew, rng_s;
  logic [15:0] pcl;
  logic        pax;
  assign pax   = (state_q == S_WAITX);
  assign q_s   = dv_neg_q ? -(A + 1)'(dv_quo) : (A + 1)'(dv_quo);
  assign rng_s = 18'(rng_q[pax ? 0 : 1]);
  always_comb begin
    if (pax || ydown_q) pnew = 18'(pos_q[pax ? 0 : 1]) + 18'(q_s);
    else pnew = 18'(pos_q[pax ? 0 : 1]) - 18'(q_s);
    if (pnew < 0) pcl = 16'd0;
    else if (pnew > rng_s) pcl = rng_q[pax ? 0 : 1];
    else pcl = pnew[15:0];
  end

  logic [CW-1:0] cnt_n;
  logic [7:0] c0;
  assign cnt_n = cnt_q + 1'b1;
  assign c0 = (cnt_q == '0) ? data_byte_i : cmd_q[0];

  // reply length of the command in cmd_q
  logic [2:0] rn_n;
  always_comb begin
    case (cmd_q[0])
      CMD_RESET:    rn_n = (cmd_q[1] == 8'h01) ? 3'd1 : 3'd0;
      CMD_INTERROG: rn_n = 3'd6;
      CMD_JOYINT:   rn_n = 3'd3;
      default:      rn_n = 3'd0;
    endcase
  end

  // load a new byte onto the output port this cycle
  logic out_set;
  always_comb begin
    case (state_q)
      S_IDLE:   out_set = in_fire && (opcode_i == OP_KEY);
      S_EMIT:   out_set = (ri_q != rn_q) && (!out_valid_q || out_ready_i);
      S_RCHUNK: out_set = !out_valid_q || out_ready_i;
      S_JOY:    out_set = (!out_valid_q || out_ready_i) &&
                          (jb_q[1] ? jpend_q[0] : jpend_q[1]);
      default:  out_set = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mode_q      <= MODE_REL;
      ax_q        <= '0;
      ay_q        <= '0;
      bstate_q    <= '0;
      posted_q    <= '0;
      bev_q       <= '0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      rng_q[0]    <= '0;
      rng_q[1]    <= '0;
      thr_q[0]    <= 8'd1;
      thr_q[1]    <= 8'd1;
      scl_q[0]    <= 8'd1;
      scl_q[1]    <= 8'd1;
      ydown_q     <= 1'b1;
      joy_q[0]    <= '0;
      joy_q[1]    <= '0;
      jpend_q     <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      rn_q        <= '0;
      ri_q        <= '0;
      nch_q       <= '0;
      cb_q        <= '0;
      jb_q        <= '0;
      dv_neg_q    <= 1'b0;
    end else begin
      if (out_set) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_fire) begin
          case (opcode_i)
            OP_HOST: begin
              cmd_q[cnt_q[IW-1:0]] <= data_byte_i;
              if (cnt_n >= CW'(cmd_len(c0)) || cnt_n >= CW'(CMD_DEPTH)) begin
                cnt_q   <= '0;
                state_q <= S_EXEC;
              end else begin
                cnt_q <= cnt_n;
              end
            end
            OP_MOVE: begin
              ax_q <= A'(sat_add(ax_q, move_x_i));
              ay_q <= A'(sat_add(ay_q, move_y_i));
            end
            OP_BTN: begin
              bstate_q[~button_index_i] <= pressed_i;
              if (button_index_i) bev_q[{1'b0, ~pressed_i}] <= 1'b1;
              else bev_q[{1'b1, ~pressed_i}] <= 1'b1;
            end
            OP_KEY: begin
              out_byte_q  <= {~pressed_i, data_byte_i[6:0]};
              out_last_q  <= 1'b1;
              state_q     <= S_DONE;
            end
            OP_JOY: begin
              if (joy_q[joystick_index_i] != data_byte_i) begin
                joy_q[joystick_index_i]   <= data_byte_i;
                jpend_q[joystick_index_i] <= 1'b1;
              end
            end
            OP_TICK: begin
              jb_q   <= '0;
              if (mode_q == MODE_REL) state_q <= S_RCHK;
              else if (mode_q == MODE_ABS) state_q <= S_DIVX;
              else begin
                ax_q    <= '0;
                ay_q    <= '0;
                state_q <= S_JOY;
              end
            end
            default: ;
          endcase
        end
        S_EXEC: begin
          // cmd_q now holds the full command
          rn_q   <= rn_n;
          ri_q   <= '0;
          state_q <= S_EMIT;
          case (cmd_q[0])
            CMD_RESET: rb_q[0] <= HDR_RESET;
            CMD_REL: mode_q <= MODE_REL;
            CMD_ABS: begin
              mode_q   <= MODE_ABS;
              rng_q[0] <= {cmd_q[1], cmd_q[2]};
              rng_q[1] <= {cmd_q[3], cmd_q[4]};
            end
            CMD_THRESH: begin
              thr_q[0] <= cmd_q[1];
              thr_q[1] <= cmd_q[2];
            end
            CMD_SCALE: begin
              scl_q[0] <= cmd_q[1];
              scl_q[1] <= cmd_q[2];
            end
            CMD_INTERROG: begin
              rb_q[0] <= HDR_POS;
              rb_q[1] <= {4'd0, bev_q};
              rb_q[2] <= pos_q[0][15:8];
              rb_q[3] <= pos_q[0][7:0];
              rb_q[4] <= pos_q[1][15:8];
              rb_q[5] <= pos_q[1][7:0];
              bev_q   <= '0;
            end
            CMD_LOADPOS: begin
              pos_q[0] <= ({cmd_q[2], cmd_q[3]} < rng_q[0]) ? {cmd_q[2], cmd_q[3]}
                                                            : rng_q[0];
              pos_q[1] <= ({cmd_q[4], cmd_q[5]} < rng_q[1]) ? {cmd_q[4], cmd_q[5]}
                                                            : rng_q[1];
            end
            CMD_YUP:     ydown_q <= 1'b0;
            CMD_YDOWN:   ydown_q <= 1'b1;
            CMD_DISABLE: mode_q  <= MODE_OFF;
            CMD_JOYINT: begin
              rb_q[0] <= HDR_JOYI;
              rb_q[1] <= joy_q[1];
              rb_q[2] <= joy_q[0];
            end
            default: ;
          endcase
        end
        S_EMIT: begin
          if (ri_q == rn_q) state_q <= S_IDLE;
          else if (!out_valid_q || out_ready_i) begin
            out_byte_q  <= rb_q[ri_q];
            out_last_q  <= (ri_q + 3'd1 == rn_q);
            ri_q        <= ri_q + 3'd1;
            if (ri_q + 3'd1 == rn_q) state_q <= S_DONE;
          end
        end
        S_RCHK: begin
          if (posted_q != bstate_q || absv(ax_q) >= (A + 1)'(thr_q[0]) ||
              absv(ay_q) >= (A + 1)'(thr_q[1])) begin
            posted_q <= bstate_q;
            rx_q     <= (A + 1)'(ax_q);
            ry_q     <= ydown_q ? (A + 1)'(ay_q) : neg_y;
            nch_q    <= '0;
            cb_q     <= '0;
            state_q  <= S_RCHUNK;
          end else state_q <= S_JOY;
        end
        S_RCHUNK: if (!out_valid_q || out_ready_i) begin
          case (cb_q)
            2'd0: begin
              out_byte_q <= HDR_REL | {6'd0, posted_q};
              out_last_q <= 1'b0;
              cb_q       <= 2'd1;
            end
            2'd1: begin
              out_byte_q <= cx[7:0];
              out_last_q <= 1'b0;
              cb_q       <= 2'd2;
            end
            default: begin
              out_byte_q <= cy[7:0];
              out_last_q <= rc_end && (jpend_q == '0);
              cb_q       <= 2'd0;
              rx_q  <= sx;
              ry_q  <= sy;
              nch_q <= nch_q + 5'd1;
              if (rc_end) begin
                ax_q <= A'(sx);
                ay_q <= ydown_q ? A'(sy) : A'(-sy);
                if (jpend_q == '0) state_q <= S_DONE;
                else state_q <= S_JOY;
              end
            end
          endcase
        end
        S_DIVX: begin
          dv_neg_q <= ax_q[A-1];
          state_q  <= S_WAITX;
        end
        S_WAITX: if (dv_done) begin
          pos_q[0] <= pcl;
          ax_q     <= dv_neg_q ? A'(-dv_rem) : dv_rem;
          state_q  <= S_DIVY;
        end
        S_DIVY: begin
          dv_neg_q <= ay_q[A-1];
          state_q  <= S_WAITY;
        end
        S_WAITY: if (dv_done) begin
          pos_q[1] <= pcl;
          ay_q     <= dv_neg_q ? A'(-dv_rem) : dv_rem;
          state_q  <= S_JOY;
        end
        S_JOY: if (!out_valid_q || out_ready_i) begin
          // phases: 0 j1 header, 1 j1 state, 2 j0 header, 3 j0 state
          if (jb_q[1] == 1'b0 && !jpend_q[1]) jb_q <= 2'd2;
          else if (jb_q[1] == 1'b1 && !jpend_q[0]) state_q <= S_DONE;
          else begin
            jb_q        <= jb_q + 2'd1;
            case (jb_q)
              2'd0: begin out_byte_q <= HDR_JOY1; out_last_q <= 1'b0; end
              2'd1: begin
                out_byte_q <= joy_q[1];
                jpend_q[1] <= 1'b0;
                out_last_q <= !jpend_q[0];
                if (!jpend_q[0]) state_q <= S_DONE;
              end
              2'd2: begin out_byte_q <= HDR_JOY0; out_last_q <= 1'b0; end
              default: begin
                out_byte_q <= joy_q[0];
                jpend_q[0] <= 1'b0;
                out_last_q <= 1'b1;
                state_q    <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: if (!out_valid_q || out_fire) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_last_q) |=> state_q == S_IDLE)
    else $error("last beat did not end event");
  a_ready_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_q)
    else $error("accepting while output pending");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CW'(CMD_DEPTH))
    else $error("command count overrun");
endmodule
`default_nettype wire

@@ rtl/kmc_div.sv @@
// Restoring divider, one quotient bit per cycle, for absolute scaling.
// Unsigned magnitude in, sign handled by caller. No dependencies.
`default_nettype none
module kmc_div #(
  parameter int unsigned N = 12
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [N-1:0] num_i,
  input  wire logic [7:0]   den_i,
  output logic              done_o,
  output logic [N-1:0]      quo_o,
  output logic [N-1:0]      rem_o
);
  localparam int unsigned CW = $clog2(N + 1);
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [N-1:0]  num_q;
  logic [N:0]    rem_q;
  logic [7:0]    den_q;
  logic [N:0]    trial;
  logic [N:0]    shifted;

  assign shifted = {rem_q[N-1:0], num_q[N-1]};
  assign trial   = shifted - {{(N - 7){1'b0}}, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(N);
        num_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
      end else if (busy_q) begin
        // shift in one numerator bit, subtract if it fits
        if (!trial[N]) begin
          rem_q <= trial;
          num_q <= {num_q[N-2:0], 1'b1};
        end else begin
          rem_q <= shifted;
          num_q <= {num_q[N-2:0], 1'b0};
        end
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign quo_o = num_q;
  assign rem_o = rem_q[N-1:0];
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for keyboard_mouse_controller: random and directed event beats
// checked byte by byte against a built-in predictor. Depends on kmc_pkg.
`timescale 1ns / 100ps
module tb;
  import kmc_pkg::*;

  class kmc_scoreboard;
    logic [7:0] cmd_buf[7];
    int         cmd_cnt;
    logic [1:0] mode;
    int         acc_x, acc_y;
    bit   [1:0] btn_now, btn_posted;
    bit   [3:0] btn_ev;
    int         pos[2], rng[2], thr[2], scl[2];
    bit         y_dn;
    logic [7:0] joy[2];
    bit         joy_chg[2];
    logic [8:0] exp_bytes[$];
    logic [8:0] beat_bytes[$];
    int         errors;

    function new();
      cmd_cnt = 0; mode = MODE_REL; acc_x = 0; acc_y = 0;
      btn_now = 0; btn_posted = 0; btn_ev = 0; y_dn = 1; errors = 0;
      for (int i = 0; i < 2; i++) begin
        pos[i] = 0; rng[i] = 0; thr[i] = 1; scl[i] = 1;
        joy[i] = 0; joy_chg[i] = 0;
      end
    endfunction

    function void put(int b);
      if (beat_bytes.size() < 55)
        beat_bytes.insert(beat_bytes.size(), {1'b0, b[7:0]});
    endfunction

    function int cmd_size(logic [7:0] op);
      case (op)
        CMD_RESET, CMD_BTNACT, CMD_JOYMON:  return 2;
        CMD_KEYCODE, CMD_THRESH, CMD_SCALE: return 3;
        CMD_ABS:                            return 5;
        CMD_LOADPOS:                        return 6;
        CMD_JOYKEYS:                        return 7;
        default:                            return 1;
      endcase
    endfunction

    function int sat12(int v);
      if (v > 2047) return 2047;
      if (v < -2048) return -2048;
      return v;
    endfunction

    function int clip_chunk(int v);
      if (v >= -128 && v < 127) return v;
      return v > 0 ? 127 : -128;
    endfunction

    function int absv(int v);
      return v < 0 ? -v : v;
    endfunction

    function void run_command();
      int x, y;
      case (cmd_buf[0])
        CMD_RESET:   if (cmd_buf[1] == 8'h01) put(HDR_RESET);
        CMD_REL:     mode = MODE_REL;
        CMD_ABS: begin
          mode = MODE_ABS;
          rng[0] = {cmd_buf[1], cmd_buf[2]};
          rng[1] = {cmd_buf[3], cmd_buf[4]};
        end
        CMD_THRESH:  begin thr[0] = cmd_buf[1]; thr[1] = cmd_buf[2]; end
        CMD_SCALE:   begin scl[0] = cmd_buf[1]; scl[1] = cmd_buf[2]; end
        CMD_INTERROG: begin
          put(HDR_POS); put(btn_ev); btn_ev = 0;
          put(pos[0] >> 8); put(pos[0]); put(pos[1] >> 8); put(pos[1]);
        end
        CMD_LOADPOS: begin
          x = {cmd_buf[2], cmd_buf[3]};
          y = {cmd_buf[4], cmd_buf[5]};
          pos[0] = x < rng[0] ? x : rng[0];
          pos[1] = y < rng[1] ? y : rng[1];
        end
        CMD_YUP:     y_dn = 0;
        CMD_YDOWN:   y_dn = 1;
        CMD_DISABLE: mode = MODE_OFF;
        CMD_JOYINT:  begin put(HDR_JOYI); put(joy[1]); put(joy[0]); end
        default: ;
      endcase
    endfunction

    function void run_tick();
      int x, y, cx, cy, n, ym, sx, sy, qx, qy;
      ym = y_dn ? 1 : -1;
      if (mode == MODE_REL) begin
        if (btn_posted != btn_now || absv(acc_x) >= thr[0] || absv(acc_y) >= thr[1]) begin
          x = acc_x; y = acc_y * ym; n = 0;
          btn_posted = btn_now;
          do begin
            cx = clip_chunk(x); cy = clip_chunk(y);
            put(HDR_REL | btn_posted); put(cx); put(cy);
            x -= cx; y -= cy; n++;
          end while ((x != 0 || y != 0) && n < 17);
          acc_x = x; acc_y = y * ym;
        end
      end else if (mode == MODE_ABS) begin
        sx = scl[0] ? scl[0] : 1;
        sy = scl[1] ? scl[1] : 1;
        qx = acc_x / sx; qy = acc_y / sy;
        pos[0] = pos[0] + qx;
        pos[0] = pos[0] < 0 ? 0 : (pos[0] > rng[0] ? rng[0] : pos[0]);
        pos[1] = pos[1] + ym * qy;
        pos[1] = pos[1] < 0 ? 0 : (pos[1] > rng[1] ? rng[1] : pos[1]);
        acc_x -= qx * sx; acc_y -= qy * sy;
      end else begin
        acc_x = 0; acc_y = 0;
      end
      if (joy_chg[1]) begin joy_chg[1] = 0; put(HDR_JOY1); put(joy[1]); end
      if (joy_chg[0]) begin joy_chg[0] = 0; put(HDR_JOY0); put(joy[0]); end
    endfunction

    function void note_event(logic [2:0] op, logic [7:0] data, logic signed [11:0] mx,
                             logic signed [11:0] my, bit bi, bit pr, bit ji);
      int idx;
      beat_bytes.delete();
      case (op)
        OP_HOST: begin
          if (cmd_cnt >= 7) cmd_cnt = 0;
          cmd_buf[cmd_cnt] = data;
          cmd_cnt++;
          if (cmd_cnt >= cmd_size(cmd_buf[0]) || cmd_cnt >= 7) begin
            run_command();
            cmd_cnt = 0;
          end
        end
        OP_MOVE: begin
          acc_x = sat12(acc_x + int'(mx));
          acc_y = sat12(acc_y + int'(my));
        end
        OP_BTN: begin
          idx = bi ^ 1'b1;
          if (pr) begin
            btn_now[idx] = 1'b1; btn_ev[2*idx] = 1'b1;
          end else begin
            btn_now[idx] = 1'b0; btn_ev[2*idx+1] = 1'b1;
          end
        end
        OP_KEY:  put({~pr, data[6:0]});
        OP_JOY: begin
          if (joy[ji] != data) begin joy[ji] = data; joy_chg[ji] = 1; end
        end
        OP_TICK: run_tick();
        default: ;
      endcase
      if (beat_bytes.size() > 0) beat_bytes[$][8] = 1'b1;
      foreach (beat_bytes[i]) exp_bytes.insert(exp_bytes.size(), beat_bytes[i]);
    endfunction

    function void check_byte(logic [7:0] b, logic l);
      logic [8:0] e;
      if (exp_bytes.size() == 0) begin
        $error("unexpected reply byte %h last %b", b, l);
        errors++;
        return;
      end
      e = exp_bytes.pop_front();
      if (b !== e[7:0]) begin
        $error("out_byte expected %h actual %h", e[7:0], b);
        errors++;
      end
      if (l !== e[8]) begin
        $error("out_last expected %b actual %b", e[8], l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic [2:0] opcode = 0;
  logic [7:0] data_byte = 0;
  logic signed [11:0] move_x = 0, move_y = 0;
  logic btn_idx = 0, pressed = 0, joy_idx = 0;
  wire in_ready, out_valid, out_last;
  wire [7:0] out_byte;

  kmc_scoreboard sb = new();
  int burst_left = 0;
  int sent = 0;
  int stall_mode = 0, stall_cnt = 0;

  always #1 clk = ~clk;

  keyboard_mouse_controller dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .data_byte_i(data_byte),
    .move_x_i(move_x), .move_y_i(move_y),
    .button_index_i(btn_idx), .pressed_i(pressed), .joystick_index_i(joy_idx),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_byte_o(out_byte), .out_last_o(out_last)
  );

  // Note the input beat before checking any reply byte of the same edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_event(opcode, data_byte, move_x, move_y, btn_idx, pressed, joy_idx);
    if (rst_n && out_valid && out_ready)
      sb.check_byte(out_byte, out_last);
  end

  // Receiver stalls: switch pattern every so often.
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt <= $urandom_range(20, 120);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (stall_cnt[2:0] != 0);
    endcase
  end

  task automatic drive_beat(logic [2:0] op, logic [7:0] d, logic signed [11:0] mx,
                            logic signed [11:0] my, bit bi, bit pr, bit ji);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    opcode <= op; data_byte <= d; move_x <= mx; move_y <= my;
    btn_idx <= bi; pressed <= pr; joy_idx <= ji;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // Unused fields carry random values so their bits toggle too.
  task automatic host(logic [7:0] b);
    drive_beat(OP_HOST, b, 12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom));
  endtask
  task automatic move(logic signed [11:0] x, logic signed [11:0] y);
    drive_beat(OP_MOVE, 8'($urandom), x, y, 1'($urandom), 1'($urandom), 1'($urandom));
  endtask
  task automatic button(bit i, bit p);
    drive_beat(OP_BTN, 8'($urandom), 12'($urandom), 12'($urandom), i, p, 1'($urandom));
  endtask
  task automatic key(logic [7:0] c, bit p);
    drive_beat(OP_KEY, c, 12'($urandom), 12'($urandom), 1'($urandom), p, 1'($urandom));
  endtask
  task automatic joystick(bit j, logic [7:0] s);
    drive_beat(OP_JOY, s, 12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom), j);
  endtask
  task automatic tick();
    drive_beat(OP_TICK, 8'($urandom), 12'($urandom), 12'($urandom), 1'($urandom),
               1'($urandom), 1'($urandom));
  endtask

  task automatic random_command();
    logic [7:0] ops[20] = '{8'h80, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d,
                            8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15,
                            8'h16, 8'h17, 8'h18, 8'h19};
    logic [7:0] op;
    int n;
    op = $urandom_range(0, 20) == 20 ? 8'h1a : ops[$urandom_range(0, 19)];
    host(op);
    n = sb.cmd_size(op);
    for (int i = 1; i < n; i++) begin
      if (op == CMD_RESET) host($urandom_range(0, 1) ? 8'h01 : 8'($urandom));
      else if ((op == CMD_ABS || op == CMD_LOADPOS) && (i % 2 == 1) &&
               $urandom_range(0, 3) != 0)
        host(8'($urandom_range(0, 2)));
      else host(8'($urandom));
    end
  endtask

  initial begin
    int sel, wait_cnt;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every event kind and every command the controller acts on.
    key(8'h7f, 1); key(8'hff, 0);
    host(CMD_RESET); host(8'h01);
    host(CMD_RESET); host(8'h02);
    host(8'h55);
    button(0, 1); button(1, 1);
    move(12'sd2047, -12'sd2048); move(12'sd2047, -12'sd2048);
    joystick(1, 8'hff); joystick(0, 8'h00); joystick(0, 8'h81);
    tick();
    host(CMD_INTERROG); host(CMD_JOYINT);
    host(CMD_THRESH); host(8'h00); host(8'hff);
    host(CMD_YUP); button(0, 0); move(-12'sd5, 12'sd300); tick();
    host(CMD_ABS); host(8'h00); host(8'h40); host(8'hff); host(8'hff);
    host(CMD_SCALE); host(8'h00); host(8'h07);
    move(-12'sd2048, 12'sd2047); tick();
    host(CMD_LOADPOS); host(8'hff); host(8'hff); host(8'hff); host(8'h10); host(8'h00);
    host(CMD_YDOWN); move(12'sd100, -12'sd100); tick(); host(CMD_INTERROG);
    host(CMD_JOYKEYS); for (int i = 0; i < 6; i++) host(8'($urandom));
    host(CMD_DISABLE); move(12'sd9, 12'sd9); tick();
    host(CMD_REL); host(CMD_THRESH); host(8'h01); host(8'h01); tick();

    while (sent < 120) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) random_command();
      else if (sel < 50) begin
        if ($urandom_range(0, 4) == 0) move(12'($urandom), 12'($urandom));
        else move($signed(12'($urandom_range(0, 400))) - 12'sd200,
                  $signed(12'($urandom_range(0, 400))) - 12'sd200);
      end
      else if (sel < 60) button(1'($urandom), 1'($urandom));
      else if (sel < 68) key(8'($urandom), 1'($urandom));
      else if (sel < 78) joystick(1'($urandom), $urandom_range(0, 1) ? 8'($urandom) : 8'h00);
      else if (sel < 95) tick();
      else host(8'($urandom));
    end

    burst_left = 0;
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (sb.exp_bytes.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (100) @(posedge clk);
    if (sb.exp_bytes.size() != 0) begin
      $error("%0d reply bytes never arrived", sb.exp_bytes.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: FAIL");
    $finish;
  end
endmodule
